@@ src/lcdns_pkg.sv @@
// shared types, constants and helper functions for the character lcd nibble sequencer
package lcdns_pkg;

  // item kinds carried on the mode field
  typedef enum logic {
    MODE_INIT = 1'b0,
    MODE_CHAR = 1'b1
  } mode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LINE_ONE_LENGTH  = 2'd0,
    CFG_LINE_TWO_END     = 2'd1,
    CFG_LINE_TWO_ADDRESS = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_W  = 7;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned WAIT_W = 3;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] LINE_ONE_LENGTH_RST  = 7'd16;
  localparam logic [CFG_W-1:0] LINE_TWO_END_RST     = 7'd32;
  localparam logic [CFG_W-1:0] LINE_TWO_ADDRESS_RST = 7'd64;

  // set display address command bit
  localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;

  // nibble counter limits: init runs 14 nibbles, a character item up to 4
  localparam logic [NIB_W-1:0] INIT_LAST_NIB  = 4'd13;
  localparam logic [NIB_W-1:0] CHAR_LAST_NIB  = 4'd3;
  localparam logic [NIB_W-1:0] CHAR_FIRST_NIB = 4'd2;

  // one decoded job for the emitter
  typedef struct packed {
    logic              is_init;
    logic              has_cmd;
    logic              cmd_wb;
    logic [BYTE_W-1:0] cmd_byte;
    logic [BYTE_W-1:0] char_code;
  } job_t;

  // nibble value of the power-on sequence: 3, 3, 3, 2, then 28 08 01 06 0c
  function automatic logic [NIB_W-1:0] init_nibble(input logic [NIB_W-1:0] nib);
    logic [NIB_W-1:0] v;
    case (nib)
      4'd0:    v = 4'h3;
      4'd1:    v = 4'h3;
      4'd2:    v = 4'h3;
      4'd3:    v = 4'h2;
      4'd4:    v = 4'h2;
      4'd5:    v = 4'h8;
      4'd6:    v = 4'h0;
      4'd7:    v = 4'h8;
      4'd8:    v = 4'h0;
      4'd9:    v = 4'h1;
      4'd10:   v = 4'h0;
      4'd11:   v = 4'h6;
      4'd12:   v = 4'h0;
      4'd13:   v = 4'hc;
      default: v = 4'h0;
    endcase
    return v;
  endfunction

  // extra wait after the final write of an init nibble
  function automatic logic [WAIT_W-1:0] init_extra(input logic [NIB_W-1:0] nib);
    logic [WAIT_W-1:0] v;
    case (nib)
      4'd0:                         v = 3'd4;
      4'd1, 4'd2, 4'd3:             v = 3'd1;
      4'd5, 4'd7, 4'd9, 4'd11, 4'd13: v = 3'd1;
      default:                      v = 3'd0;
    endcase
    return v;
  endfunction

  // bit order reversal onto the data pins
  function automatic logic [NIB_W-1:0] rev4(input logic [NIB_W-1:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

@@ src/lcdns_decode.sv @@
// configuration registers and decode of one item into an emitter job
module lcdns_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_en,
  input  logic [1:0]                  cfg_index,
  input  logic [lcdns_pkg::CFG_W-1:0] cfg_data,
  input  logic                        mode,
  input  logic [lcdns_pkg::POS_W-1:0] position,
  input  logic [7:0]                  char_code,
  input  logic                        first,
  output lcdns_pkg::job_t             job,
  output logic                        job_valid
);

  logic [lcdns_pkg::CFG_W-1:0] line_one_length;
  logic [lcdns_pkg::CFG_W-1:0] line_two_end;
  logic [lcdns_pkg::CFG_W-1:0] line_two_address;
  logic                        on_line_one;
  logic                        on_line_two;
  logic [7:0]                  line_two_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_one_length  <= lcdns_pkg::LINE_ONE_LENGTH_RST;
      line_two_end     <= lcdns_pkg::LINE_TWO_END_RST;
      line_two_address <= lcdns_pkg::LINE_TWO_ADDRESS_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        lcdns_pkg::CFG_LINE_ONE_LENGTH:  line_one_length  <= cfg_data;
        lcdns_pkg::CFG_LINE_TWO_END:     line_two_end     <= cfg_data;
        lcdns_pkg::CFG_LINE_TWO_ADDRESS: line_two_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // line classification and cursor address
  assign on_line_one  = position < line_one_length;
  assign on_line_two  = !on_line_one && (position < line_two_end);
  assign line_two_cmd = ({1'b0, line_two_address} - {1'b0, line_one_length}
                         + {1'b0, position}) | lcdns_pkg::CMD_SET_ADDR;

  // job fields
  always_comb begin
    job.is_init   = (mode == lcdns_pkg::MODE_INIT);
    job.char_code = char_code;
    job.has_cmd   = 1'b0;
    job.cmd_wb    = 1'b0;
    job.cmd_byte  = {1'b0, position} | lcdns_pkg::CMD_SET_ADDR;
    job_valid     = 1'b1;
    if (mode == lcdns_pkg::MODE_CHAR) begin
      if (on_line_one) begin
        job.has_cmd = first;
      end else if (on_line_two) begin
        job.has_cmd  = first || (position == line_one_length);
        job.cmd_wb   = 1'b1;
        job.cmd_byte = line_two_cmd;
      end else begin
        job_valid = 1'b0;
      end
    end
  end

endmodule

@@ src/lcdns_emit.sv @@
// job register, nibble and strobe counters, and the pin write output register
module lcdns_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lcdns_pkg::job_t              job_in,
  input  logic                         job_valid,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcdns_pkg::NIB_W-1:0]  data_pins,
  output logic                         reg_select,
  output logic                         enable,
  output logic                         wait_before_ms,
  output logic [lcdns_pkg::WAIT_W-1:0] wait_after_ms,
  output logic                         last
);

  // three pin writes per nibble
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_STROBE = 2'd1,
    PH_TAIL   = 2'd2
  } phase_t;

  lcdns_pkg::job_t             job;
  logic                        busy;
  phase_t                      phase;
  logic [lcdns_pkg::NIB_W-1:0] nib;

  logic                         load;
  logic                         accept;
  logic [lcdns_pkg::NIB_W-1:0]  last_nib;
  logic                         wr_last;
  logic [lcdns_pkg::NIB_W-1:0]  nib_val;
  logic                         rs_val;
  logic                         wb_val;
  logic [lcdns_pkg::WAIT_W-1:0] extra_val;

  // handshake
  assign load     = busy && (!out_valid || !out_stall);
  assign last_nib = job.is_init ? lcdns_pkg::INIT_LAST_NIB : lcdns_pkg::CHAR_LAST_NIB;
  assign wr_last  = (phase == PH_TAIL) && (nib == last_nib);
  assign in_stall = busy && !(load && wr_last);
  assign accept   = in_valid && !in_stall;

  // current nibble and its attributes
  always_comb begin
    nib_val   = '0;
    rs_val    = 1'b0;
    wb_val    = 1'b0;
    extra_val = '0;
    if (job.is_init) begin
      nib_val   = lcdns_pkg::init_nibble(nib);
      extra_val = lcdns_pkg::init_extra(nib);
    end else begin
      case (nib[1:0])
        2'd0: begin
          nib_val = job.cmd_byte[7:4];
          wb_val  = job.cmd_wb;
        end
        2'd1: nib_val = job.cmd_byte[3:0];
        2'd2: begin
          nib_val = job.char_code[7:4];
          rs_val  = 1'b1;
          wb_val  = 1'b1;
        end
        default: begin
          nib_val = job.char_code[3:0];
          rs_val  = 1'b1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_LEAD;
      nib   <= '0;
    end else if (accept && job_valid) begin
      busy  <= 1'b1;
      phase <= PH_LEAD;
      nib   <= (job_in.is_init || job_in.has_cmd) ? 4'd0 : lcdns_pkg::CHAR_FIRST_NIB;
    end else if (load) begin
      if (phase == PH_TAIL) begin
        phase <= PH_LEAD;
        nib   <= nib + 4'd1;
      end else begin
        phase <= phase_t'(phase + 2'd1);
      end
      if (wr_last) begin
        busy <= 1'b0;
      end
    end
  end

  // job register
  always_ff @(posedge clk) begin
    if (accept && job_valid) begin
      job <= job_in;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_pins      <= lcdns_pkg::rev4(nib_val);
      reg_select     <= rs_val;
      enable         <= (phase == PH_STROBE);
      wait_before_ms <= (phase == PH_LEAD) && wb_val;
      wait_after_ms  <= (phase == PH_TAIL) ? 3'd1 + extra_val : 3'd1;
      last           <= wr_last;
    end
  end

endmodule

@@ src/char_lcd_nibble_sequencer_top.sv @@
// top level of the character lcd 4-bit nibble sequencer
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   in      | in_valid / in_stall  | mode, position, char_code, first
//   out     | out_valid/ out_stall | data_pins, reg_select, enable, wait_before_ms,
//           |                      | wait_after_ms, last
//   cfg     | cfg_en               | cfg_index, cfg_data
//
// one pin write leaves per cycle from the output register unless out stalls;
// an item has 42 writes for init, 6 or 12 for a character, none for a dropped one.
// the next item is taken in the cycle the current item's last write is loaded.
// reset is synchronous: config returns to 16 / 32 / 64 and the output is emptied.
// a stall on out freezes the counters and holds the output transaction.
module char_lcd_nibble_sequencer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_en,
  input  logic [1:0]                   cfg_index,
  input  logic [lcdns_pkg::CFG_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [lcdns_pkg::POS_W-1:0]  position,
  input  logic [7:0]                   char_code,
  input  logic                         first,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcdns_pkg::NIB_W-1:0]  data_pins,
  output logic                         reg_select,
  output logic                         enable,
  output logic                         wait_before_ms,
  output logic [lcdns_pkg::WAIT_W-1:0] wait_after_ms,
  output logic                         last
);

  lcdns_pkg::job_t job;
  logic            job_valid;

  // item decode and configuration
  lcdns_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .position  (position),
    .char_code (char_code),
    .first     (first),
    .job       (job),
    .job_valid (job_valid)
  );

  // pin write sequencing
  lcdns_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .job_in         (job),
    .job_valid      (job_valid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_pins      (data_pins),
    .reg_select     (reg_select),
    .enable         (enable),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

endmodule

@@ src/lcdns_checker.sv @@
// port-level checks on the nibble sequencer and their bind to the top level
module lcdns_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] data_pins,
  input logic       enable,
  input logic       wait_before_ms,
  input logic [2:0] wait_after_ms,
  input logic       last
);

  // output is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_pins) && $stable(last))
    else $error("stalled output transaction changed");

  // the strobe write is never the final write of an item
  a_strobe_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable |-> !last)
    else $error("enable high on final write");

  // a wait before only opens a nibble, with enable low
  a_wait_before_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_before_ms |-> !enable && !last && wait_after_ms == 3'd1)
    else $error("wait before on a non-leading write");

  // every write waits at least one millisecond after, at most five
  a_wait_after_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wait_after_ms != 3'd0 && wait_after_ms != 3'd6 && wait_after_ms != 3'd7)
    else $error("wait after out of range");

endmodule

bind char_lcd_nibble_sequencer_top lcdns_checker u_lcdns_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .data_pins      (data_pins),
  .enable         (enable),
  .wait_before_ms (wait_before_ms),
  .wait_after_ms  (wait_after_ms),
  .last           (last)
);
